// File: rtl/core/ik_pkg.sv
package ik_pkg;

    // fixed formats of the datapath
    localparam int LEN_W       = 15;
    localparam int SERVO_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int TRIG_W      = 16;
    localparam int ONE_Q14     = 16384;
    localparam int DIV_STEPS   = 14;
    localparam int SQRT_STEPS  = 15;
    localparam int SQRT_W      = 30;
    localparam int REM_W       = 32;
    localparam int TAB_LEN     = 24;
    localparam int Z_W         = 28;
    localparam int ANG_W       = 17;
    localparam int ANG_SH      = 11;
    localparam int ANG_RND     = 1024;
    localparam int SCALE_SH    = 20;
    localparam int GUARD_W     = 23;
    localparam int HALF_PI_Q24 = 26353589;
    localparam int COUNTS_K    = 12816876;
    localparam int COUNTS_W    = 25;
    localparam int COUNTS_SH   = 29;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_ARM    = 2'd0,
        CFG_FOREARM      = 2'd1,
        CFG_SERVO_CENTER = 2'd2
    } cfg_reg_t;

    // pipeline control handed to each unit
    typedef struct packed {
        logic valid;
        logic en;
    } pipe_ctl_t;

    // atan(2^-i) in Q.24, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_tab(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            20: v = 28'sd16;
            21: v = 28'sd8;
            22: v = 28'sd4;
            23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/ik_if.sv
// target point channel
interface ik_target_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          elbow_up;

    modport source (output valid, point_x, point_y, elbow_up, input ready);
    modport sink   (input valid, point_x, point_y, elbow_up, output ready);
endinterface

// servo command channel
interface ik_command_if;
    logic                        valid;
    logic                        ready;
    logic [ik_pkg::SERVO_W-1:0]  shoulder_position;
    logic [ik_pkg::SERVO_W-1:0]  elbow_position;

    modport source (output valid, shoulder_position, elbow_position, input ready);
    modport sink   (input valid, shoulder_position, elbow_position, output ready);
endinterface

// configuration write channel
interface ik_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ik_pkg::CFG_IDX_W-1:0]  index;
    logic [ik_pkg::LEN_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ik_cos_unit.sv
module ik_cos_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int TAG_W       = 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ik_pkg::pipe_ctl_t                  ctl,
    input  logic signed [COORD_WIDTH-1:0]      x,
    input  logic signed [COORD_WIDTH-1:0]      y,
    input  logic [TAG_W-1:0]                   tag_in,
    input  logic [ik_pkg::LEN_W-1:0]           l1,
    input  logic [ik_pkg::LEN_W-1:0]           l2,
    output logic                               out_valid,
    output logic signed [ik_pkg::TRIG_W-1:0]   c,
    output logic [TAG_W-1:0]                   tag_out
);

    localparam int AW = 2 * COORD_WIDTH;
    localparam int SW = ((AW > ik_pkg::REM_W) ? AW : ik_pkg::REM_W) + 1;
    localparam int NS = ik_pkg::DIV_STEPS;
    localparam int RW = ik_pkg::REM_W;

    logic                    v0_reg, v1_reg;
    logic [COORD_WIDTH-1:0]  ax_reg, ay_reg;
    logic [TAG_W-1:0]        tag0_reg, tag1_reg;
    logic [AW-1:0]           a_reg;
    logic [RW-1:0]           b_reg, den1_reg;
    logic [RW-1:0]           l1w, l2w;
    logic [SW-1:0]           aw, bw, dw;
    logic                    hi, lo;

    logic                    vd_reg    [0:NS];
    logic [TAG_W-1:0]        tagd_reg  [0:NS];
    logic [RW-1:0]           rem_reg   [0:NS];
    logic [RW-1:0]           den_reg   [0:NS];
    logic [NS-1:0]           q_reg     [0:NS];
    logic                    clamp_reg [0:NS];
    logic                    neg_reg   [0:NS];

    assign l1w = RW'(l1);
    assign l2w = RW'(l2);

    // magnitudes of the target coordinates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v0_reg <= ctl.valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            ax_reg   <= x[COORD_WIDTH-1] ? COORD_WIDTH'(-x) : COORD_WIDTH'(x);
            ay_reg   <= y[COORD_WIDTH-1] ? COORD_WIDTH'(-y) : COORD_WIDTH'(y);
            tag0_reg <= tag_in;
            // squared reach and law of cosines terms
            a_reg    <= AW'(AW'(ax_reg) * AW'(ax_reg)) + AW'(AW'(ay_reg) * AW'(ay_reg));
            b_reg    <= RW'(l1w * l1w) + RW'(l2w * l2w);
            den1_reg <= RW'(l1w * l2w) << 1;
            tag1_reg <= tag0_reg;
        end
    end

    // saturation checks and numerator magnitude
    assign aw = SW'(a_reg);
    assign bw = SW'(b_reg);
    assign dw = SW'(den1_reg);
    assign hi = aw >= bw + dw;
    assign lo = aw + dw <= bw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg[0] <= 1'b0;
        else if (ctl.en)
            vd_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            tagd_reg[0]  <= tag1_reg;
            den_reg[0]   <= den1_reg;
            q_reg[0]     <= '0;
            clamp_reg[0] <= hi || lo;
            neg_reg[0]   <= hi ? 1'b0 : (lo ? 1'b1 : (aw < bw));
            rem_reg[0]   <= (aw < bw) ? RW'(bw - aw) : RW'(aw - bw);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        logic [RW-1:0] r2;
        logic          take;

        assign r2   = rem_reg[k] << 1;
        assign take = r2 >= den_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vd_reg[k+1] <= 1'b0;
            else if (ctl.en)
                vd_reg[k+1] <= vd_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[k+1]   <= take ? r2 - den_reg[k] : r2;
                q_reg[k+1]     <= {q_reg[k][NS-2:0], take};
                den_reg[k+1]   <= den_reg[k];
                tagd_reg[k+1]  <= tagd_reg[k];
                clamp_reg[k+1] <= clamp_reg[k];
                neg_reg[k+1]   <= neg_reg[k];
            end
        end
    end

    // signed cosine, truncated toward zero
    always_comb
    begin
        if (clamp_reg[NS])
            c = neg_reg[NS] ? -(ik_pkg::TRIG_W)'(ik_pkg::ONE_Q14)
                            : (ik_pkg::TRIG_W)'(ik_pkg::ONE_Q14);
        else if (neg_reg[NS])
            c = -(ik_pkg::TRIG_W)'(q_reg[NS]);
        else
            c = (ik_pkg::TRIG_W)'(q_reg[NS]);
    end

    assign out_valid = vd_reg[NS];
    assign tag_out   = tagd_reg[NS];

endmodule

// File: rtl/core/ik_sqrt.sv
module ik_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ik_pkg::pipe_ctl_t                 ctl,
    input  logic signed [ik_pkg::TRIG_W-1:0]  c_in,
    input  logic [TAG_W-1:0]                  tag_in,
    output logic                              out_valid,
    output logic signed [ik_pkg::TRIG_W-1:0]  c_out,
    output logic [ik_pkg::LEN_W-1:0]          s,
    output logic [TAG_W-1:0]                  tag_out
);

    localparam int NS = ik_pkg::SQRT_STEPS;
    localparam int QW = ik_pkg::SQRT_W;

    logic                             v_reg   [0:NS];
    logic [QW-1:0]                    rad_reg [0:NS];
    logic [QW-1:0]                    root_reg[0:NS];
    logic signed [ik_pkg::TRIG_W-1:0] c_reg   [0:NS];
    logic [TAG_W-1:0]                 tag_reg [0:NS];
    logic signed [2*ik_pkg::TRIG_W-1:0] csq;

    assign csq = c_in * c_in;

    // radicand 1 - c^2 in Q2.28
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (ctl.en)
            v_reg[0] <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rad_reg[0]  <= QW'(ik_pkg::ONE_Q14 * ik_pkg::ONE_Q14) - QW'(csq);
            root_reg[0] <= '0;
            c_reg[0]    <= c_in;
            tag_reg[0]  <= tag_in;
        end
    end

    // digit-by-digit square root, one result bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_root
        localparam logic [QW-1:0] BIT = QW'(1) << (2 * (NS - 1 - k));
        logic [QW-1:0] trial;

        assign trial = root_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (ctl.en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                if (rad_reg[k] >= trial)
                begin
                    rad_reg[k+1]  <= rad_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rad_reg[k+1]  <= rad_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
                c_reg[k+1]   <= c_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign c_out     = c_reg[NS];
    assign s         = root_reg[NS][ik_pkg::LEN_W-1:0];
    assign tag_out   = tag_reg[NS];

endmodule

// File: rtl/core/ik_cordic.sv
module ik_cordic #(
    parameter int IN_W  = 32,
    parameter int LANES = 3,
    parameter int STEPS = 16,
    parameter int TAG_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ik_pkg::pipe_ctl_t                ctl,
    input  logic signed [IN_W-1:0]           yv [LANES],
    input  logic signed [IN_W-1:0]           xv [LANES],
    input  logic [TAG_W-1:0]                 tag_in,
    output logic                             out_valid,
    output logic signed [ik_pkg::ANG_W-1:0]  ang [LANES],
    output logic [TAG_W-1:0]                 tag_out
);

    localparam int W  = IN_W + ik_pkg::GUARD_W;
    localparam int ZW = ik_pkg::Z_W;

    logic                 v_reg   [0:STEPS];
    logic [TAG_W-1:0]     tag_reg [0:STEPS];
    logic [LANES-1:0]     zf_reg  [0:STEPS];
    logic signed [W-1:0]  x_reg   [0:STEPS][LANES];
    logic signed [W-1:0]  y_reg   [0:STEPS][LANES];
    logic signed [ZW-1:0] z_reg   [0:STEPS][LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (ctl.en)
            v_reg[0] <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            tag_reg[0] <= tag_in;
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_pre
        logic signed [W-1:0] xs, ys;

        assign xs = W'(xv[l]) <<< ik_pkg::SCALE_SH;
        assign ys = W'(yv[l]) <<< ik_pkg::SCALE_SH;

        // scale up and rotate the left half plane into the right one
        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                zf_reg[0][l] <= (xv[l] == '0) && (yv[l] == '0);
                if (xs < 0 && ys >= 0)
                begin
                    x_reg[0][l] <= ys;
                    y_reg[0][l] <= -xs;
                    z_reg[0][l] <= ZW'(ik_pkg::HALF_PI_Q24);
                end
                else if (xs < 0)
                begin
                    x_reg[0][l] <= -ys;
                    y_reg[0][l] <= xs;
                    z_reg[0][l] <= -ZW'(ik_pkg::HALF_PI_Q24);
                end
                else
                begin
                    x_reg[0][l] <= xs;
                    y_reg[0][l] <= ys;
                    z_reg[0][l] <= '0;
                end
            end
        end
    end

    // vectoring micro-rotations, one per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] ATN = ik_pkg::atan_tab(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (ctl.en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                tag_reg[i+1] <= tag_reg[i];
                zf_reg[i+1]  <= zf_reg[i];
            end
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    if (y_reg[i][l] > 0)
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] + ATN;
                    end
                    else
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] - ATN;
                    end
                end
            end
        end
    end

    // round the accumulated angle to Q3.13
    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        logic signed [ZW-1:0] zr;

        assign zr     = z_reg[STEPS][l] + ZW'(ik_pkg::ANG_RND);
        assign ang[l] = zf_reg[STEPS][l] ? '0
                                         : zr[ik_pkg::ANG_SH +: ik_pkg::ANG_W];
    end

    assign out_valid = v_reg[STEPS];
    assign tag_out   = tag_reg[STEPS];

    // the x/y of the last stage are not needed beyond the angle
    logic unused_xy;
    assign unused_xy = ^{x_reg[STEPS][0], y_reg[STEPS][0]};

endmodule

// File: rtl/core/two_link_arm_inverse_kinematics.sv
// two-link planar arm inverse kinematics
//
// target channel: a point (point_x, point_y) in signed Q12.4 mm and the
// elbow choice; command channel: shoulder and elbow servo commands 0..1023.
// cfg channel: writes upper_arm_length (index 0), forearm_length (index 1)
// and servo_center (index 2); ready is always high, other indexes are
// dropped. write configuration only while no point is in flight.
//
// the block is one pipeline: law of cosines and a 14-stage divider, a
// 15-stage square root, one stage of link products, a three-lane CORDIC of
// CORDIC_STEPS + 1 stages, then angle difference, scaling and saturation.
// one point is taken every cycle unless a finished command is held back.
//
// reset empties the pipeline and loads the register defaults (1600, 1600,
// 512). when the receiver stalls a valid command, the whole pipeline holds
// and target ready drops in the same cycle; nothing is lost or repeated.
module two_link_arm_inverse_kinematics #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int SERVO_MAX    = 1023
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ik_target_if.sink                  target,
    ik_command_if.source               command,
    ik_cfg_if.sink                     cfg
);

    localparam int TAG_W  = 2 * COORD_WIDTH + 1;
    localparam int KW     = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam int TW     = ik_pkg::TRIG_W;
    localparam int AW     = ik_pkg::ANG_W + 1;
    localparam int PW     = AW + ik_pkg::COUNTS_W;
    localparam int VW     = 15;

    logic                          en;
    ik_pkg::pipe_ctl_t             ctl_cos, ctl_sq, ctl_cd;
    logic [ik_pkg::LEN_W-1:0]      upper_arm_length_reg, forearm_length_reg;
    logic [ik_pkg::SERVO_W-1:0]    servo_center_reg;

    logic                          cos_valid, sq_valid, cd_valid;
    logic signed [TW-1:0]          cos_c, sq_c;
    logic [ik_pkg::LEN_W-1:0]      sq_s;
    logic [TAG_W-1:0]              cos_tag, sq_tag;

    logic                          k_valid_reg;
    logic signed [KW-1:0]          k1_reg, k2_reg, tx_reg, ty_reg, ec_reg, es_reg;
    logic                          k_up_reg;
    logic signed [KW-1:0]          cd_y [3];
    logic signed [KW-1:0]          cd_x [3];
    logic signed [ik_pkg::ANG_W-1:0] cd_ang [3];
    logic                          cd_up;
    logic signed [TW-1:0]          sq_sgn;

    logic                          a_valid_reg, b_valid_reg, out_valid_reg;
    logic signed [AW-1:0]          sh_ang_reg, el_ang_reg;
    logic signed [PW-1:0]          sh_prod_reg, el_prod_reg;
    logic [ik_pkg::SERVO_W-1:0]    sh_pos_reg, el_pos_reg;

    // truncate toward zero, offset by the center, saturate
    function automatic logic [ik_pkg::SERVO_W-1:0] to_servo(
        input logic signed [PW-1:0]         prod,
        input logic [ik_pkg::SERVO_W-1:0]   center
    );
        logic signed [PW-1:0] biased;
        logic signed [PW-1:0] cnt;
        logic signed [VW-1:0] v;
        logic [ik_pkg::SERVO_W-1:0] r;
        biased = prod + (prod[PW-1] ? PW'((64'd1 << ik_pkg::COUNTS_SH) - 1) : PW'(0));
        cnt    = biased >>> ik_pkg::COUNTS_SH;
        v      = VW'(center) + VW'(cnt);
        if (v < 0)
            r = '0;
        else if (v > VW'(SERVO_MAX))
            r = ik_pkg::SERVO_W'(SERVO_MAX);
        else
            r = v[ik_pkg::SERVO_W-1:0];
        return r;
    endfunction

    // whole pipeline moves unless a finished command is held back
    assign en           = !out_valid_reg || command.ready;
    assign target.ready = en;
    assign cfg.ready    = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_arm_length_reg <= ik_pkg::LEN_W'(1600);
            forearm_length_reg   <= ik_pkg::LEN_W'(1600);
            servo_center_reg     <= ik_pkg::SERVO_W'(512);
        end
        else if (cfg.valid)
        begin
            unique case (ik_pkg::cfg_reg_t'(cfg.index))
                ik_pkg::CFG_UPPER_ARM:    upper_arm_length_reg <= cfg.data;
                ik_pkg::CFG_FOREARM:      forearm_length_reg   <= cfg.data;
                ik_pkg::CFG_SERVO_CENTER: servo_center_reg     <= cfg.data[ik_pkg::SERVO_W-1:0];
                default: ;
            endcase
        end
    end

    // elbow cosine
    assign ctl_cos = '{valid: target.valid, en: en};

    ik_cos_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .TAG_W       (TAG_W)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_cos),
        .x         (target.point_x),
        .y         (target.point_y),
        .tag_in    ({target.elbow_up, target.point_x, target.point_y}),
        .l1        (upper_arm_length_reg),
        .l2        (forearm_length_reg),
        .out_valid (cos_valid),
        .c         (cos_c),
        .tag_out   (cos_tag)
    );

    // elbow sine
    assign ctl_sq = '{valid: cos_valid, en: en};

    ik_sqrt #(
        .TAG_W (TAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_sq),
        .c_in      (cos_c),
        .tag_in    (cos_tag),
        .out_valid (sq_valid),
        .c_out     (sq_c),
        .s         (sq_s),
        .tag_out   (sq_tag)
    );

    // link products for the shoulder offset angle
    assign sq_sgn = sq_tag[TAG_W-1] ? TW'(sq_s) : -TW'(sq_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_valid_reg <= 1'b0;
        else if (en)
            k_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg   <= (KW'(upper_arm_length_reg) <<< 14)
                        + KW'($signed({1'b0, forearm_length_reg})) * KW'(sq_c);
            k2_reg   <= KW'($signed({1'b0, forearm_length_reg})) * KW'(sq_sgn);
            tx_reg   <= KW'($signed(sq_tag[2*COORD_WIDTH-1:COORD_WIDTH]));
            ty_reg   <= KW'($signed(sq_tag[COORD_WIDTH-1:0]));
            ec_reg   <= KW'(sq_c);
            es_reg   <= KW'(sq_s);
            k_up_reg <= sq_tag[TAG_W-1];
        end
    end

    // lane 0 elbow, lane 1 target bearing, lane 2 link offset
    assign cd_y[0] = es_reg;
    assign cd_x[0] = ec_reg;
    assign cd_y[1] = ty_reg;
    assign cd_x[1] = tx_reg;
    assign cd_y[2] = k2_reg;
    assign cd_x[2] = k1_reg;
    assign ctl_cd  = '{valid: k_valid_reg, en: en};

    ik_cordic #(
        .IN_W  (KW),
        .LANES (3),
        .STEPS (CORDIC_STEPS),
        .TAG_W (1)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_cd),
        .yv        (cd_y),
        .xv        (cd_x),
        .tag_in    (k_up_reg),
        .out_valid (cd_valid),
        .ang       (cd_ang),
        .tag_out   (cd_up)
    );

    // joint angles, then scaling to servo counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= cd_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_ang_reg  <= AW'(cd_ang[1]) - AW'(cd_ang[2]);
            el_ang_reg  <= cd_up ? AW'(cd_ang[0]) : -AW'(cd_ang[0]);
            sh_prod_reg <= PW'(sh_ang_reg) * PW'(ik_pkg::COUNTS_K);
            el_prod_reg <= PW'(el_ang_reg) * PW'(ik_pkg::COUNTS_K);
            sh_pos_reg  <= to_servo(sh_prod_reg, servo_center_reg);
            el_pos_reg  <= to_servo(el_prod_reg, servo_center_reg);
        end
    end

    assign command.valid             = out_valid_reg;
    assign command.shoulder_position = sh_pos_reg;
    assign command.elbow_position    = el_pos_reg;

    // a held command blocks new targets
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !command.ready |-> !target.ready)
        else $error("target taken while command stalled");

    // clamped cosine stays within one
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        cos_valid |-> (cos_c <= TW'(ik_pkg::ONE_Q14)) && (cos_c >= -TW'(ik_pkg::ONE_Q14)))
        else $error("elbow cosine out of range");

    // sine never exceeds one
    a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> sq_s <= ik_pkg::LEN_W'(ik_pkg::ONE_Q14))
        else $error("elbow sine out of range");

    // a stalled pipeline keeps its scaling products
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !en |=> $stable(sh_prod_reg) && $stable(el_prod_reg))
        else $error("pipeline moved during stall");

endmodule
